// ===== sv/assert_macros.svh =====
// assertion macros shared by the cone sector test rtl
// no dependencies; defining NO_ASSERTIONS turns every use into nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property that must hold at every clock edge out of reset
`define PICS_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
		else $error(msg);
// antecedent in one cycle implies consequent in the next
`define PICS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PICS_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define PICS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

// ===== sv/pics_pkg.sv =====
// shared constants, types and helper functions of the cone sector test
// no dependencies; imported by pics_div, pics_cordic and the top level
package pics_pkg;

	// local coordinate width after saturation, Q16.16
	localparam int COORD_W = 32;
	localparam longint SAT_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
	localparam longint SAT_MIN = -(longint'(1) <<< (COORD_W - 1));

	// pipelined divider geometry
	localparam int DIV_NW  = 64;
	localparam int DIV_DW  = 33;
	localparam int DIV_QW  = 49;
	localparam int DIV_LAT = DIV_QW;

	// cordic geometry
	localparam int CORDIC_STEPS = 17;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
	localparam int ANG_PAD      = DIV_LAT - CORDIC_LAT;
	localparam int CX_W         = 34;
	localparam int CZ_W         = 20;
	localparam int ANG_W        = 19;

	localparam logic [ANG_W-1:0] ANG_PI      = ANG_W'(205887);
	localparam logic [ANG_W-1:0] ANG_TWO_PI  = ANG_W'(411775);
	localparam logic [ANG_W-1:0] ANG_HALF_PI = ANG_W'(102944);

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_XY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_ZR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SECTOR  = 3'd6;

	// data travelling alongside the dividers
	typedef struct packed {
		logic [30:0] tol;
		logic        hneg;
		logic        hfail;
		logic [63:0] sumsq;
	} side_t;

	// atan(2^-i) in Q16.16 radians
	function automatic logic signed [CZ_W-1:0] atan_val(input int i);
		logic signed [CZ_W-1:0] v;
		case (i)
			0: v = CZ_W'(51472);
			1: v = CZ_W'(30386);
			2: v = CZ_W'(16055);
			3: v = CZ_W'(8150);
			4: v = CZ_W'(4091);
			5: v = CZ_W'(2047);
			6: v = CZ_W'(1024);
			7: v = CZ_W'(512);
			8: v = CZ_W'(256);
			9: v = CZ_W'(128);
			10: v = CZ_W'(64);
			11: v = CZ_W'(32);
			12: v = CZ_W'(16);
			13: v = CZ_W'(8);
			14: v = CZ_W'(4);
			15: v = CZ_W'(2);
			default: v = CZ_W'(1);
		endcase
		return v;
	endfunction

	// magnitude of a signed 32 bit value
	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

// ===== sv/pics_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// depends on pics_pkg for its geometry
module pics_div import pics_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic [DIV_QW-1:0] quo,
	output logic              ovf
);

	logic [DIV_DW-1:0] rem_q [DIV_QW];
	logic [DIV_QW-1:0] quo_q [DIV_QW];
	logic [DIV_NW-1:0] num_q [DIV_QW];
	logic              ovf_q [DIV_QW];

	genvar j;
	generate
		for (j = 0; j < DIV_QW; j++) begin : g_stage
			logic [DIV_DW-1:0] rem_p;
			logic [DIV_QW-1:0] quo_p;
			logic [DIV_NW-1:0] num_p;
			logic              ovf_p;
			logic [DIV_DW:0]   trial;
			logic              ge;
			logic [DIV_QW-1:0] quo_n;

			// previous stage, or the operands for the first one
			if (j == 0) begin : g_first
				assign rem_p = DIV_DW'(num[DIV_NW-1:DIV_QW]);
				assign quo_p = '0;
				assign num_p = num;
				assign ovf_p = (DIV_DW'(num[DIV_NW-1:DIV_QW]) >= den);
			end else begin : g_next
				assign rem_p = rem_q[j-1];
				assign quo_p = quo_q[j-1];
				assign num_p = num_q[j-1];
				assign ovf_p = ovf_q[j-1];
			end

			// bring down one numerator bit and try a subtract
			always_comb begin
				trial = {rem_p, num_p[DIV_QW-1-j]};
				ge    = (trial >= {1'b0, den});
				quo_n = quo_p;
				quo_n[DIV_QW-1-j] = ge;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[j] <= ge ? DIV_DW'(trial - {1'b0, den}) : DIV_DW'(trial);
					quo_q[j] <= quo_n;
					num_q[j] <= num_p;
					ovf_q[j] <= ovf_p;
				end
			end
		end
	endgenerate

	assign quo = quo_q[DIV_QW-1];
	assign ovf = ovf_q[DIV_QW-1];

endmodule

// ===== sv/pics_cordic.sv =====
// pipelined cordic vectoring unit giving the polar angle in [0, 2pi]
// depends on pics_pkg for the atan table and angle constants
module pics_cordic import pics_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [COORD_W-1:0] ax,
	input  logic signed [COORD_W-1:0] ay,
	output logic [ANG_W-1:0]         ang
);

	logic signed [CX_W-1:0] x_q [CORDIC_STEPS+1];
	logic signed [CX_W-1:0] y_q [CORDIC_STEPS+1];
	logic signed [CZ_W-1:0] z_q [CORDIC_STEPS+1];
	logic                   xz_q [CORDIC_STEPS+1];
	logic                   yz_q [CORDIC_STEPS+1];
	logic                   xn_q [CORDIC_STEPS+1];
	logic                   yn_q [CORDIC_STEPS+1];
	logic [ANG_W-1:0]       ang_q;

	logic [31:0] axm, aym, mor, ux, uy;

	// magnitudes, scaled together below 2^30
	always_comb begin
		axm = mag32(32'(ax));
		aym = mag32(32'(ay));
		mor = axm | aym;
		if (mor[31]) begin
			ux = axm >> 2;
			uy = aym >> 2;
		end else if (mor[30]) begin
			ux = axm >> 1;
			uy = aym >> 1;
		end else begin
			ux = axm;
			uy = aym;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]  <= CX_W'(ux);
			y_q[0]  <= CX_W'(uy);
			z_q[0]  <= '0;
			xz_q[0] <= (ux == 32'd0);
			yz_q[0] <= (uy == 32'd0);
			xn_q[0] <= ax[COORD_W-1];
			yn_q[0] <= ay[COORD_W-1];
		end
	end

	// one rotation per stage
	genvar k;
	generate
		for (k = 1; k <= CORDIC_STEPS; k++) begin : g_iter
			logic signed [CX_W-1:0] dx, dy;
			assign dx = y_q[k-1] >>> (k - 1);
			assign dy = x_q[k-1] >>> (k - 1);
			always_ff @(posedge clk) begin
				if (en) begin
					if (y_q[k-1] > 0) begin
						x_q[k] <= x_q[k-1] + dx;
						y_q[k] <= y_q[k-1] - dy;
						z_q[k] <= z_q[k-1] + atan_val(k - 1);
					end else begin
						x_q[k] <= x_q[k-1] - dx;
						y_q[k] <= y_q[k-1] + dy;
						z_q[k] <= z_q[k-1] - atan_val(k - 1);
					end
					xz_q[k] <= xz_q[k-1];
					yz_q[k] <= yz_q[k-1];
					xn_q[k] <= xn_q[k-1];
					yn_q[k] <= yn_q[k-1];
				end
			end
		end
	endgenerate

	logic signed [CZ_W-1:0] zf;
	logic [ANG_W-1:0] q1, ang_n;

	// special axes, clamp, then quadrant mapping
	always_comb begin
		zf = z_q[CORDIC_STEPS];
		if (yz_q[CORDIC_STEPS])
			q1 = '0;
		else if (xz_q[CORDIC_STEPS])
			q1 = ANG_HALF_PI;
		else if (zf < 0)
			q1 = '0;
		else if (zf > $signed({1'b0, ANG_HALF_PI}))
			q1 = ANG_HALF_PI;
		else
			q1 = ANG_W'(zf);
		if (!yn_q[CORDIC_STEPS])
			ang_n = xn_q[CORDIC_STEPS] ? (ANG_PI - q1) : q1;
		else
			ang_n = xn_q[CORDIC_STEPS] ? (ANG_PI + q1) : (ANG_TWO_PI - q1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_q <= ang_n;
		end
	end

	assign ang = ang_q;

endmodule

// ===== sv/point_in_cone_sector_test.sv =====
// top level of the cone sector membership test, fully pipelined
// depends on pics_pkg, pics_div, pics_cordic and assert_macros.svh
//
// channel | signals                                   | moves
// --------+-------------------------------------------+------------------------
// in      | in_valid/in_ready                         | point_x/y/z, slack
// out     | out_valid/out_ready                       | inside_res
// cfg     | cfg_valid/cfg_ready (always ready)        | cfg_index, cfg_data
//
// one transaction enters per cycle unless a result is held at the output;
// it passes through 56 register stages, 49 of them in the divider
// that scales the radius by height
// reset clears the valid bits and loads the default frame and cone
// a result held at the output freezes the whole pipeline; nothing is lost
`include "assert_macros.svh"

module point_in_cone_sector_test import pics_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [31:0]   point_x,
	input  logic signed [31:0]   point_y,
	input  logic signed [31:0]   point_z,
	input  logic [30:0]          slack,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 inside_res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	// configuration registers
	logic [47:0] rot_x_q, rot_y_q, rot_z_q;
	logic [63:0] shift_xy_q, shift_zr_q, height_q, sector_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_x_q    <= 48'd16384;
			rot_y_q    <= 48'd1073741824;
			rot_z_q    <= 48'd70368744177664;
			shift_xy_q <= 64'd0;
			shift_zr_q <= 64'd281474976710656;
			height_q   <= 64'd9223372034707292160;
			sector_q   <= 64'd1768560158310400;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROT_X:    rot_x_q    <= cfg_data[47:0];
				REG_ROT_Y:    rot_y_q    <= cfg_data[47:0];
				REG_ROT_Z:    rot_z_q    <= cfg_data[47:0];
				REG_SHIFT_XY: shift_xy_q <= cfg_data;
				REG_SHIFT_ZR: shift_zr_q <= cfg_data;
				REG_HEIGHT:   height_q   <= cfg_data;
				REG_SECTOR:   sector_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// decoded configuration
	logic [47:0]        rot_row [3];
	logic signed [31:0] shift_v [3];
	logic signed [31:0] pt [3];
	logic signed [31:0] rad, za, zb, zs, ze, sa, sb, as_v, ae_v;
	logic signed [32:0] hgt33;
	logic [31:0]        hgt_u, radm;
	logic               rad_neg, rad_zero, height_zero;

	always_comb begin
		rot_row[0] = rot_x_q;
		rot_row[1] = rot_y_q;
		rot_row[2] = rot_z_q;
		shift_v[0] = $signed(shift_xy_q[31:0]);
		shift_v[1] = $signed(shift_xy_q[63:32]);
		shift_v[2] = $signed(shift_zr_q[31:0]);
		pt[0] = point_x;
		pt[1] = point_y;
		pt[2] = point_z;
		rad = $signed(shift_zr_q[63:32]);
		radm = mag32(rad);
		rad_neg = rad[31];
		rad_zero = (rad == 32'sd0);
		za = $signed(height_q[31:0]);
		zb = $signed(height_q[63:32]);
		zs = (za < zb) ? za : zb;
		ze = (za < zb) ? zb : za;
		hgt33 = 33'(ze) - 33'(zs);
		hgt_u = hgt33[31:0];
		height_zero = (za == zb);
		sa = $signed(sector_q[31:0]);
		sb = $signed(sector_q[63:32]);
		as_v = (sa < sb) ? sa : sb;
		ae_v = (sa < sb) ? sb : sa;
	end

	// the whole pipeline moves together unless the output is held
	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s54, v_s55, v_s56;
	logic v_dly_q [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++)
				v_dly_q[i] <= 1'b0;
			v_s54 <= 1'b0;
			v_s55 <= 1'b0;
			v_s56 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_dly_q[0] <= v_s4;
			for (int i = 1; i < DIV_LAT; i++)
				v_dly_q[i] <= v_dly_q[i-1];
			v_s54 <= v_dly_q[DIV_LAT-1];
			v_s55 <= v_s54;
			v_s56 <= v_s55;
		end
	end

	// stage 1: rotation products
	logic signed [47:0] prod_s1 [3][3];
	logic [30:0]        tol_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					prod_s1[r][c] <= $signed(rot_row[r][16*c +: 16]) * pt[c];
			tol_s1 <= slack;
		end
	end

	// stage 2: row sums, rounding shift, translation, saturation
	logic signed [49:0]        acc [3];
	logic signed [36:0]        tr [3];
	logic signed [COORD_W-1:0] loc [3];
	logic signed [COORD_W-1:0] ax_s2, ay_s2, lz_s2;
	logic [30:0]               tol_s2;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = 50'(prod_s1[r][0]) + 50'(prod_s1[r][1]) + 50'(prod_s1[r][2])
				+ 50'sd8192;
			tr[r] = 37'(acc[r] >>> 14) + 37'(shift_v[r]);
			if (tr[r] > SAT_MAX)
				loc[r] = COORD_W'(SAT_MAX);
			else if (tr[r] < SAT_MIN)
				loc[r] = COORD_W'(SAT_MIN);
			else
				loc[r] = COORD_W'(tr[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s2  <= loc[0];
			ay_s2  <= loc[1];
			lz_s2  <= loc[2];
			tol_s2 <= tol_s1;
		end
	end

	// stage 3: height offset and z span check, squared distances
	logic signed [33:0]        h_v, tol34, hgt34;
	logic signed [COORD_W-1:0] ax_s3, ay_s3;
	logic [31:0]               habs_s3;
	logic [63:0]               sx_s3, sy_s3;
	logic [30:0]               tol_s3;
	logic                      hneg_s3, hfail_s3;

	always_comb begin
		h_v   = 34'(lz_s2) - 34'(zs);
		tol34 = $signed({3'b000, tol_s2});
		hgt34 = $signed({2'b00, hgt_u});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hneg_s3  <= h_v[33];
			habs_s3  <= h_v[33] ? 32'(-h_v) : 32'(h_v);
			hfail_s3 <= (h_v < -tol34) || (h_v > hgt34 + tol34);
			sx_s3    <= mag32(32'(ax_s2)) * mag32(32'(ax_s2));
			sy_s3    <= mag32(32'(ay_s2)) * mag32(32'(ay_s2));
			ax_s3    <= ax_s2;
			ay_s3    <= ay_s2;
			tol_s3   <= tol_s2;
		end
	end

	// stage 4: radius numerator and distance sum
	logic [63:0]               num_s4, sumsq_s4;
	logic signed [COORD_W-1:0] ax_s4, ay_s4;
	logic [30:0]               tol_s4;
	logic                      hneg_s4, hfail_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s4   <= habs_s3 * radm;
			sumsq_s4 <= sx_s3 + sy_s3;
			ax_s4    <= ax_s3;
			ay_s4    <= ay_s3;
			tol_s4   <= tol_s3;
			hneg_s4  <= hneg_s3;
			hfail_s4 <= hfail_s3;
		end
	end

	// radius scale and angular tolerance dividers, cordic alongside
	logic [DIV_QW-1:0] quo_r, quo_a;
	logic              ovf_r, ovf_a;
	logic [ANG_W-1:0]  ang_c;

	pics_div u_div_rad (
		.clk (clk),
		.en  (adv),
		.num (num_s4),
		.den ({1'b0, hgt_u}),
		.quo (quo_r),
		.ovf (ovf_r)
	);

	pics_div u_div_tol (
		.clk (clk),
		.en  (adv),
		.num (DIV_NW'({tol_s4, 16'd0})),
		.den ({1'b0, radm}),
		.quo (quo_a),
		.ovf (ovf_a)
	);

	pics_cordic u_cordic (
		.clk (clk),
		.en  (adv),
		.ax  (ax_s4),
		.ay  (ay_s4),
		.ang (ang_c)
	);

	// side data and angle delayed to meet the divider results
	side_t            side_dly_q [DIV_LAT];
	logic [ANG_W-1:0] ang_dly_q [ANG_PAD];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_dly_q[0] <= '{tol: tol_s4, hneg: hneg_s4, hfail: hfail_s4,
				sumsq: sumsq_s4};
			for (int i = 1; i < DIV_LAT; i++)
				side_dly_q[i] <= side_dly_q[i-1];
			ang_dly_q[0] <= ang_c;
			for (int i = 1; i < ANG_PAD; i++)
				ang_dly_q[i] <= ang_dly_q[i-1];
		end
	end

	// stage 54: capped local radius plus slack, angle bounds
	side_t              sd;
	logic [DIV_QW-1:0]  qm_v;
	logic signed [50:0] r_v;
	logic signed [49:0] atol_v;
	logic [48:0]        rabs_s54;
	logic signed [50:0] lo_s54, hi_s54;
	logic [ANG_W-1:0]   ang_s54;
	logic [63:0]        sumsq_s54;
	logic               hfail_s54;

	always_comb begin
		sd = side_dly_q[DIV_LAT-1];
		if (ovf_r || (quo_r > (DIV_QW'(1) << 48)))
			qm_v = DIV_QW'(1) << 48;
		else
			qm_v = quo_r;
		if (sd.hneg != rad_neg)
			r_v = -$signed({2'b00, qm_v});
		else
			r_v = $signed({2'b00, qm_v});
		r_v = r_v + $signed({20'd0, sd.tol});
		// tolerance quotient stays below 2^47 for a nonzero radius, so no overflow arises
		atol_v = rad_neg ? -$signed({1'b0, quo_a}) : $signed({1'b0, quo_a});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rabs_s54  <= r_v[50] ? 49'(-r_v) : 49'(r_v);
			lo_s54    <= 51'(as_v) - 51'(atol_v);
			hi_s54    <= 51'(ae_v) + 51'(atol_v);
			ang_s54   <= ang_dly_q[ANG_PAD-1];
			sumsq_s54 <= sd.sumsq;
			hfail_s54 <= sd.hfail;
		end
	end

	// stage 55: radius square partial products, angle span check
	logic [47:0]        p_hh_s55;
	logic [48:0]        p_hl_s55;
	logic [49:0]        p_ll_s55;
	logic [63:0]        sumsq_s55;
	logic               hfail_s55, angfail_s55;
	logic signed [50:0] ang_sv;

	assign ang_sv = $signed({32'd0, ang_s54});

	always_ff @(posedge clk) begin
		if (adv) begin
			p_hh_s55    <= rabs_s54[48:25] * rabs_s54[48:25];
			p_hl_s55    <= rabs_s54[48:25] * rabs_s54[24:0];
			p_ll_s55    <= rabs_s54[24:0] * rabs_s54[24:0];
			sumsq_s55   <= sumsq_s54;
			hfail_s55   <= hfail_s54;
			// the tolerance divider overflows only for a zero radius, where this check is skipped
			angfail_s55 <= !rad_zero && ((ang_sv < lo_s54) || (ang_sv > hi_s54));
		end
	end

	// stage 56: distance against radius, final verdict
	logic [97:0] rsq;
	logic        res_s56;

	assign rsq = {p_hh_s55, 50'd0} + {23'd0, p_hl_s55, 26'd0} + {48'd0, p_ll_s55};

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s56 <= !hfail_s55 && !angfail_s55 && !({34'd0, sumsq_s55} > rsq);
		end
	end

	assign out_valid  = v_s56;
	assign inside_res = res_s56 && !height_zero;

	// checks
	`PICS_ASSERT(a_empty_height, clk, arst_n, !(out_valid && height_zero && inside_res), "empty height gave an inside result")
	`PICS_ASSERT_NEXT(a_stall_hold, clk, arst_n, !adv, $stable(v_s1) && $stable(v_s4) && $stable(v_s55), "pipeline moved during a stall")
	`PICS_ASSERT(a_angle_range, clk, arst_n, !v_s54 || (ang_s54 <= ANG_TWO_PI), "polar angle beyond two pi")
	`PICS_ASSERT(a_tol_no_ovf, clk, arst_n, !v_dly_q[DIV_LAT-1] || rad_zero || !ovf_a, "tolerance quotient overflowed")

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for point_in_cone_sector_test: predicts inside_res per point
// depends on pics_pkg for the register indexes; drives in, out and cfg channels
module tb_top;
	import pics_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint HALF_PI_Q = 102944;
	localparam longint PI_Q      = 205887;
	localparam longint TWO_PI_Q  = 411775;
	localparam int     N_PHASES  = 11;
	localparam int     PHASE_ITEMS = 190;

	// scoreboard of expected inside flags
	class inside_board;
		bit exp_q[$];
		int fails;
		function new();
			fails = 0;
		endfunction
		function void note_point(bit expected);
			exp_q.push_back(expected);
		endfunction
		function void check_result(bit actual);
			bit e;
			if (exp_q.size() == 0) begin
				$display("%0t: unexpected result inside_res=%0d", $realtime, actual);
				fails++;
				return;
			end
			e = exp_q.pop_front();
			if (e !== actual) begin
				$display("%0t: inside_res mismatch expected %0d actual %0d",
					$realtime, e, actual);
				fails++;
			end
		endfunction
		function int pending();
			return exp_q.size();
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
	logic [30:0] slack = '0;
	logic out_valid;
	logic out_ready = 0;
	logic inside_res;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	inside_board board = new();
	logic [63:0] cone_regs [7];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	longint geo_scale = 64'd1 << 16;

	point_in_cone_sector_test dut (.*);

	always #6 clk = ~clk;

	// predictor helpers
	function automatic longint sx32(logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic logic [63:0] mag64(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint local_coord(logic [47:0] row, longint px, longint py,
		longint pz, longint shift);
		longint e0, e1, e2, acc, v;
		e0 = longint'(signed'(row[15:0]));
		e1 = longint'(signed'(row[31:16]));
		e2 = longint'(signed'(row[47:32]));
		acc = e0 * px + e1 * py + e2 * pz + 64'sd8192;
		v = (acc >>> 14) + shift;
		if (v > SAT_MAX) v = SAT_MAX;
		if (v < SAT_MIN) v = SAT_MIN;
		return v;
	endfunction

	// first quadrant angle by cordic vectoring
	function automatic longint quad_angle(logic [63:0] ux, logic [63:0] uy);
		longint x, y, z, dx, dy;
		longint atans [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
			128, 64, 32, 16, 8, 4, 2, 1};
		z = 0;
		while ((ux | uy) >= (64'd1 << 30)) begin
			ux = ux >> 1;
			uy = uy >> 1;
		end
		if (uy == 0) return 0;
		if (ux == 0) return HALF_PI_Q;
		x = longint'(ux);
		y = longint'(uy);
		for (int i = 0; i < 17; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += atans[i];
			end else begin
				x -= dx; y += dy; z -= atans[i];
			end
		end
		if (z < 0) z = 0;
		if (z > HALF_PI_Q) z = HALF_PI_Q;
		return z;
	endfunction

	// expected membership of one point under the current registers
	function automatic bit predict_inside(logic [31:0] px, logic [31:0] py,
		logic [31:0] pz, logic [30:0] sl);
		longint tol, za, zb, zs, ze, height, ax, ay, lz, h, rad, r, q1, ang;
		longint atol, aa, ab, as_, ae;
		logic [63:0] qm, tm;
		logic [127:0] d2, rr;
		tol = longint'({33'b0, sl});
		za = sx32(cone_regs[REG_HEIGHT][31:0]);
		zb = sx32(cone_regs[REG_HEIGHT][63:32]);
		zs = za < zb ? za : zb;
		ze = za < zb ? zb : za;
		height = ze - zs;
		if (height <= 0) return 1'b0;
		ax = local_coord(cone_regs[REG_ROT_X][47:0], sx32(px), sx32(py), sx32(pz),
			sx32(cone_regs[REG_SHIFT_XY][31:0]));
		ay = local_coord(cone_regs[REG_ROT_Y][47:0], sx32(px), sx32(py), sx32(pz),
			sx32(cone_regs[REG_SHIFT_XY][63:32]));
		lz = local_coord(cone_regs[REG_ROT_Z][47:0], sx32(px), sx32(py), sx32(pz),
			sx32(cone_regs[REG_SHIFT_ZR][31:0]));
		h = lz - zs;
		if (h < -tol || h > height + tol) return 1'b0;
		// local radius, capped, widened by the tolerance
		rad = sx32(cone_regs[REG_SHIFT_ZR][63:32]);
		qm = (mag64(h) * mag64(rad)) / 64'(height);
		if (qm > (64'd1 << 48)) qm = 64'd1 << 48;
		r = ((h < 0) != (rad < 0)) ? -longint'(qm) : longint'(qm);
		r += tol;
		d2 = {64'b0, mag64(ax)} * {64'b0, mag64(ax)} + {64'b0, mag64(ay)} * {64'b0, mag64(ay)};
		rr = {64'b0, mag64(r)} * {64'b0, mag64(r)};
		if (d2 > rr) return 1'b0;
		// polar angle in [0, 2pi]
		q1 = quad_angle(mag64(ax), mag64(ay));
		if (ay >= 0) ang = (ax >= 0) ? q1 : PI_Q - q1;
		else ang = (ax >= 0) ? TWO_PI_Q - q1 : PI_Q + q1;
		if (rad != 0) begin
			tm = ({33'b0, sl} << 16) / mag64(rad);
			atol = rad < 0 ? -longint'(tm) : longint'(tm);
			aa = sx32(cone_regs[REG_SECTOR][31:0]);
			ab = sx32(cone_regs[REG_SECTOR][63:32]);
			as_ = aa < ab ? aa : ab;
			ae = aa < ab ? ab : aa;
			if (ang < as_ - atol) return 1'b0;
			if (ang > ae + atol) return 1'b0;
		end
		return 1'b1;
	endfunction

	// register write transaction, model updated on acceptance
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_ROT_Z) cone_regs[idx] = {16'b0, val[47:0]};
		else if (idx <= REG_SECTOR) cone_regs[idx] = val;
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// point transaction with random idle gaps before it
	task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
		logic [30:0] sl);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		slack <= sl;
		do @(posedge clk); while (!in_ready);
		board.note_point(predict_inside(px, py, pz, sl));
	endtask

	function automatic logic [31:0] near_val();
		longint v;
		v = longint'($urandom_range(0, 32'(4 * geo_scale))) - 2 * geo_scale;
		return 32'(v);
	endfunction

	function automatic logic [30:0] rand_slack();
		case ($urandom_range(3))
			0: return '0;
			1: return 31'($urandom_range(0, 32'(geo_scale / 4)));
			2: return 31'($urandom_range(0, 32'(geo_scale)));
			default: return 31'($urandom);
		endcase
	endfunction

	task automatic send_random_point();
		if ($urandom_range(99) < 70)
			send_point(near_val(), near_val(), near_val(), rand_slack());
		else
			send_point($urandom, $urandom, $urandom, 31'($urandom));
	endtask

	function automatic logic [47:0] pack_row(logic [15:0] e0, logic [15:0] e1,
		logic [15:0] e2);
		return {e2, e1, e0};
	endfunction

	// new frame and cone for a phase; some phases force a corner case
	task automatic configure_phase(int ph);
		logic [15:0] one_q, m_one, rnd [9];
		logic [31:0] rad, za, zb, aa, ab;
		int rot_kind;
		one_q = 16'h4000;
		m_one = 16'hc000;
		geo_scale = 64'd1 << (16 + $urandom_range(0, 8));
		foreach (rnd[i]) rnd[i] = 16'($urandom);
		rot_kind = (ph == 4) ? 3 : (ph == 5) ? 4 : $urandom_range(0, 2);
		case (rot_kind)
			0: begin
				write_reg(REG_ROT_X, pack_row(one_q, 16'd0, 16'd0));
				write_reg(REG_ROT_Y, pack_row(16'd0, one_q, 16'd0));
				write_reg(REG_ROT_Z, pack_row(16'd0, 16'd0, one_q));
			end
			1: begin
				write_reg(REG_ROT_X, pack_row(16'd0, m_one, 16'd0));
				write_reg(REG_ROT_Y, pack_row(16'd0, 16'd0, one_q));
				write_reg(REG_ROT_Z, pack_row(m_one, 16'd0, 16'd0));
			end
			2: begin
				write_reg(REG_ROT_X, pack_row(rnd[0] >>> 2, rnd[1] >>> 2, rnd[2] >>> 2));
				write_reg(REG_ROT_Y, pack_row(rnd[3] >>> 2, rnd[4] >>> 2, rnd[5] >>> 2));
				write_reg(REG_ROT_Z, pack_row(rnd[6] >>> 2, rnd[7] >>> 2, rnd[8] >>> 2));
			end
			3: begin
				write_reg(REG_ROT_X, {16'hffff, 48'h7fff_8000_7fff});
				write_reg(REG_ROT_Y, pack_row(16'h8000, 16'h8000, 16'h8000));
				write_reg(REG_ROT_Z, pack_row(16'h7fff, 16'h7fff, 16'h7fff));
			end
			default: begin
				write_reg(REG_ROT_X, {$urandom, $urandom});
				write_reg(REG_ROT_Y, {$urandom, $urandom});
				write_reg(REG_ROT_Z, {$urandom, $urandom});
			end
		endcase
		za = near_val();
		zb = near_val();
		if (ph == 3) zb = za;
		rad = 32'($urandom_range(0, 32'(geo_scale)));
		if (ph == 1) rad = 0;
		if (ph == 2) rad = -rad - 1;
		aa = 32'($urandom_range(0, 420000)) - 32'd20000;
		ab = 32'($urandom_range(0, 420000)) - 32'd20000;
		if (ph == 4) begin
			write_reg(REG_SHIFT_XY, {32'h7fffffff, 32'h80000000});
			write_reg(REG_SHIFT_ZR, {32'h7fffffff, 32'h80000000});
			write_reg(REG_HEIGHT, {32'h80000000, 32'h7fffffff});
			write_reg(REG_SECTOR, {32'h80000000, 32'h7fffffff});
		end else if (ph == 5) begin
			write_reg(REG_SHIFT_XY, {$urandom, $urandom});
			write_reg(REG_SHIFT_ZR, {$urandom, $urandom});
			write_reg(REG_HEIGHT, {$urandom, $urandom});
			write_reg(REG_SECTOR, {$urandom, $urandom});
		end else if (ph == 6) begin
			write_reg(REG_SHIFT_XY, '0);
			write_reg(REG_SHIFT_ZR, {32'h80000000, 32'h0});
			write_reg(REG_HEIGHT, {zb, za});
			write_reg(REG_SECTOR, '1);
		end else begin
			write_reg(REG_SHIFT_XY, {32'(near_val() >>> 2), 32'(near_val() >>> 2)});
			write_reg(REG_SHIFT_ZR, {rad, 32'(near_val() >>> 2)});
			write_reg(REG_HEIGHT, {zb, za});
			write_reg(REG_SECTOR, {ab, aa});
		end
		// index beyond the register list must be ignored
		write_reg(3'd7, {$urandom, $urandom});
		end_writes();
	endtask

	task automatic set_idling(int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
			default: begin send_idle_pct = 29; recv_stall_pct = 29; end
		endcase
	endtask

	task automatic wait_drained();
		while (board.pending() != 0) @(posedge clk);
	endtask

	// result side: ready changes on the falling edge, results checked on the rising
	always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_result(inside_res);
	end

	// stimulus
	initial begin
		cone_regs[0] = 64'd16384;
		cone_regs[1] = 64'd1073741824;
		cone_regs[2] = 64'd70368744177664;
		cone_regs[3] = 64'd0;
		cone_regs[4] = 64'd281474976710656;
		cone_regs[5] = 64'd9223372034707292160;
		cone_regs[6] = 64'd1768560158310400;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed points under the reset frame
		set_idling(0);
		send_point(0, 0, 0, 31'd0);
		send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
		send_point(32'h80000000, 32'h80000000, 32'h80000000, 31'd0);
		send_point(32'h80000000, 0, 32'h7fffffff, 31'h7fffffff);
		send_point(32'h00010000, 0, 32'h00050000, 31'd0);
		send_point(0, 32'h00010000, 32'h00050000, 31'd0);
		send_point(32'hffff0000, 0, 32'h00050000, 31'd0);
		send_point(0, 32'hffff0000, 32'h00050000, 31'd0);
		send_point(32'h7fffffff, 1, 32'h7fff0000, 31'd0);
		send_point(32'h7fffffff, 32'hffffffff, 32'h7fff0000, 31'd0);
		send_point(32'h40000000, 32'hffffffff, 32'h7fff0000, 31'h100);
		send_point(32'h00008000, 32'h00008000, 0, 31'h10000);
		send_point(32'h00020000, 0, 32'h80000000, 31'h10000);
		send_point(32'hffff8000, 32'hffff8000, 32'h00010000, 31'd0);
		send_point(0, 0, 32'h80000000, 31'h7fffffff);
		@(negedge clk);
		in_valid <= 0;

		for (int ph = 1; ph < N_PHASES; ph++) begin
			@(negedge clk);
			in_valid <= 0;
			wait_drained();
			configure_phase(ph);
			set_idling(ph);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// short run without idling inside each phase
				if (n == PHASE_ITEMS / 2) set_idling(0);
				send_random_point();
			end
		end
		@(negedge clk);
		in_valid <= 0;

		wait_drained();
		repeat (80) @(posedge clk);
		if (board.fails == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/pics_pkg.sv
sv/pics_div.sv
sv/pics_cordic.sv
sv/point_in_cone_sector_test.sv
dv/tb_top.sv
